[src/did_pkg.sv]
// shared types, constants and helpers of the derivative-integration detector
package did_pkg;

  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned LEAK_FRAC_BITS_DEF = 8;
  localparam int unsigned INT_BITS           = 32;
  localparam int unsigned SUM_BITS           = INT_BITS + 2;
  localparam int unsigned FILTER_SHIFT       = 2;
  localparam int unsigned CFG_IDX_BITS       = 2;
  localparam int unsigned CFG_DATA_BITS      = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INT_THR   = 2'd0,
    REG_DERIV_THR = 2'd1,
    REG_LEAK      = 2'd2,
    REG_FILT_EN   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                       detected;
    logic signed [INT_BITS-1:0] integ;
    logic signed [INT_BITS-1:0] carried;
  } integ_res_t;

  // clamp a wide signed value into the signed integral range
  function automatic logic signed [INT_BITS-1:0] sat_int(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = {{(SUM_BITS-INT_BITS+1){1'b0}}, {(INT_BITS-1){1'b1}}};
    lo = {{(SUM_BITS-INT_BITS+1){1'b1}}, {(INT_BITS-1){1'b0}}};
    if (v > hi) begin
      sat_int = hi[INT_BITS-1:0];
    end else if (v < lo) begin
      sat_int = lo[INT_BITS-1:0];
    end else begin
      sat_int = v[INT_BITS-1:0];
    end
  endfunction

endpackage

[src/did_if.sv]
// valid/ready channel interfaces for sample beats and result beats
interface did_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

interface did_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                        valid;
  logic                        ready;
  logic                        detected;
  logic signed [31:0]          integral_value;
  logic signed [SAMPLE_BITS:0] derivative_value;
  logic [SAMPLE_BITS-1:0]      average_value;

  modport source (output valid, detected, integral_value, derivative_value, average_value,
                  input ready);
  modport sink   (input valid, detected, integral_value, derivative_value, average_value,
                  output ready);
endinterface

[src/did_filter.sv]
// moving-average update and derivative of the average
module did_filter import did_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                        kind_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [SAMPLE_BITS-1:0]      avg_i,
  input  logic                        pending_i,
  input  logic                        filt_en_i,
  output logic [SAMPLE_BITS-1:0]      avg_o,
  output logic signed [SAMPLE_BITS:0] deriv_o,
  output logic                        pending_o
);

  localparam int unsigned AccBits = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] base;
  logic [AccBits-1:0]     acc;
  logic [SAMPLE_BITS-1:0] iir;

  // first baseline beat seeds the average with the sample itself
  assign base = (!kind_i && pending_i) ? sample_i : avg_i;
  assign acc  = ({3'b000, base} << 1) + {3'b000, base} + {3'b000, sample_i};
  assign iir  = acc[FILTER_SHIFT +: SAMPLE_BITS];

  always_comb begin
    if (!kind_i) begin
      avg_o     = iir;
      deriv_o   = '0;
      pending_o = 1'b0;
    end else begin
      avg_o     = filt_en_i ? iir : sample_i;
      deriv_o   = $signed({1'b0, avg_o}) - $signed({1'b0, avg_i});
      pending_o = pending_i;
    end
  end

endmodule

[src/did_integ.sv]
// thresholded integration of the derivative, detection compare and leak
module did_integ import did_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned LEAK_FRAC_BITS = LEAK_FRAC_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS:0]  deriv_i,
  input  logic signed [INT_BITS-1:0]   carried_i,
  input  logic [SAMPLE_BITS-1:0]       deriv_thr_i,
  input  logic signed [INT_BITS-1:0]   int_thr_i,
  input  logic [LEAK_FRAC_BITS:0]      leak_i,
  output integ_res_t                   res_o
);

  localparam int unsigned ProdBits = INT_BITS + LEAK_FRAC_BITS + 1;

  logic [SAMPLE_BITS:0]        dmag;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [INT_BITS-1:0]  integ;
  logic                        neg;
  logic [INT_BITS-1:0]         mag;
  logic [ProdBits-1:0]         prod;
  logic [INT_BITS:0]           shr;
  logic signed [SUM_BITS-1:0]  leaked;

  assign dmag = deriv_i[SAMPLE_BITS] ? (~deriv_i + 1'b1) : deriv_i;
  assign sum  = {{2{carried_i[INT_BITS-1]}}, carried_i}
              + {{(SUM_BITS-SAMPLE_BITS-1){deriv_i[SAMPLE_BITS]}}, deriv_i};
  assign integ = (dmag > {1'b0, deriv_thr_i}) ? sat_int(sum) : carried_i;

  // leak works on the magnitude so the shift truncates toward zero
  assign neg    = integ[INT_BITS-1];
  assign mag    = neg ? (~integ + 1'b1) : integ;
  assign prod   = {{(LEAK_FRAC_BITS+1){1'b0}}, mag}
                * {{INT_BITS{1'b0}}, leak_i};
  assign shr    = prod[LEAK_FRAC_BITS +: INT_BITS+1];
  assign leaked = neg ? -$signed({1'b0, shr}) : $signed({1'b0, shr});

  always_comb begin
    res_o.integ    = integ;
    res_o.detected = (integ >= int_thr_i);
    res_o.carried  = res_o.detected ? integ : sat_int(leaked);
  end

endmodule

[src/derivative_integration_detector_core.sv]
// top level of the derivative-integration proximity detector
//
// usage:
//   in_i   sample beats: kind (0 baseline, 1 detection) and an unsigned sample
//   out_o  result beats: detected flag, saturated integral, derivative of the
//          moving average and the average after the beat
//   cfg_*  register writes: integral threshold, derivative threshold, leak
//          fraction, filter enable; write only while the block is idle
// timing:
//   one result beat per sample beat; a sample beat is accepted into the input
//   register, then moves on to the result register, where out_o.valid rises,
//   once that register is free; one beat per cycle while out_o.ready stays
//   high, bounded by the combinational filter, integrate and leak update of
//   the carried average and integral
// reset:
//   both stages empty, configuration registers zero, average and integral zero, the next
//   baseline beat seeds the average
// stall:
//   a held result keeps its register; the input stage still takes a beat
//   while it is empty, then in_i.ready drops until out_o.ready returns
module derivative_integration_detector_core import did_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned LEAK_FRAC_BITS = LEAK_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  did_in_if.sink                   in_i,
  did_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // configuration registers
  logic signed [INT_BITS-1:0]  int_thr_q;
  logic [SAMPLE_BITS-1:0]      deriv_thr_q;
  logic [LEAK_FRAC_BITS:0]     leak_q;
  logic                        filt_en_q;

  // input stage
  logic                        in_vld_q;
  logic                        kind_q;
  logic [SAMPLE_BITS-1:0]      sample_q;

  // carried detector state
  logic [SAMPLE_BITS-1:0]      avg_q;
  logic signed [INT_BITS-1:0]  carried_q;
  logic                        pending_q;

  // result stage
  logic                        out_vld_q;
  logic                        det_q;
  logic signed [INT_BITS-1:0]  integ_q;
  logic signed [SAMPLE_BITS:0] deriv_q;
  logic [SAMPLE_BITS-1:0]      avg_out_q;

  logic                        out_free;
  logic                        advance;
  logic [SAMPLE_BITS-1:0]      avg_d;
  logic signed [SAMPLE_BITS:0] deriv_d;
  logic                        pending_d;
  integ_res_t                  integ_res;

  // handshake: the result register frees up when empty or being taken
  assign out_free   = !out_vld_q || out_o.ready;
  assign advance    = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_thr_q   <= '0;
      deriv_thr_q <= '0;
      leak_q      <= '0;
      filt_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INT_THR:   int_thr_q   <= cfg_data_i[INT_BITS-1:0];
        REG_DERIV_THR: deriv_thr_q <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_LEAK:      leak_q      <= cfg_data_i[LEAK_FRAC_BITS:0];
        REG_FILT_EN:   filt_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q   <= in_i.kind;
      sample_q <= in_i.sample;
    end
  end

  did_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .kind_i    (kind_q),
    .sample_i  (sample_q),
    .avg_i     (avg_q),
    .pending_i (pending_q),
    .filt_en_i (filt_en_q),
    .avg_o     (avg_d),
    .deriv_o   (deriv_d),
    .pending_o (pending_d)
  );

  did_integ #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .LEAK_FRAC_BITS (LEAK_FRAC_BITS)
  ) u_integ (
    .deriv_i     (deriv_d),
    .carried_i   (carried_q),
    .deriv_thr_i (deriv_thr_q),
    .int_thr_i   (int_thr_q),
    .leak_i      (leak_q),
    .res_o       (integ_res)
  );

  // state moves only when a beat leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q     <= '0;
      carried_q <= '0;
      pending_q <= 1'b1;
    end else if (advance) begin
      avg_q     <= avg_d;
      pending_q <= pending_d;
      if (kind_q) begin
        carried_q <= integ_res.carried;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  // baseline beats report zero detection, integral and derivative
  always_ff @(posedge clk_i) begin
    if (advance) begin
      det_q     <= kind_q && integ_res.detected;
      integ_q   <= kind_q ? integ_res.integ : '0;
      deriv_q   <= deriv_d;
      avg_out_q <= avg_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.detected         = det_q;
  assign out_o.integral_value   = integ_q;
  assign out_o.derivative_value = deriv_q;
  assign out_o.average_value    = avg_out_q;

endmodule
